@@ hdl/pcse_pkg.sv @@
// ----------------------------------------------------------------------------
// pcse_pkg
// Shared types, codes and constants of the phase cycle signal evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcse_pkg;

    // default sizes of the stores
    localparam int MAX_PULSES_DEF = 8;
    localparam int MAX_STEPS_DEF  = 64;
    localparam int MAX_BASE_DEF   = 256;

    // item field widths
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 3;
    localparam int SA_W      = 8;
    localparam int VAL_W     = 9;
    localparam int TRIG_W    = 16;
    localparam int MAG_OUT_W = 22;
    localparam int ANG_W     = 16;
    localparam int PHASE_W   = 8;
    localparam int JUMP_W    = 6;

    // configuration register widths
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 44;
    localparam int STEP_CNT_W  = 7;
    localparam int BASE_CFG_W  = 9;
    localparam int PULSE_CNT_W = 4;
    localparam int CUTOFF_W    = 44;

    // angle unit
    localparam int CORDIC_STEPS = 21;
    localparam int CORDIC_IW    = 5;
    localparam int CW           = 34;  // vector component width
    localparam int ZW           = 26;  // angle accumulator, pi = 2^22
    localparam int NORM_BIT     = 30;

    localparam logic signed [ZW-1:0]    Z_PI          = ZW'(4194304);
    localparam logic signed [ANG_W-1:0] ANG_POS_MAX   = 16'sh7FFF;
    localparam logic signed [ANG_W-1:0] ANG_NEG_MIN   = 16'sh8000;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER   = 16'sh4000;
    localparam logic signed [ANG_W-1:0] ANG_NEG_QUART = 16'shC000;

    typedef enum logic [CMD_W-1:0] {
        CMD_PHASE = 3'd0,
        CMD_RECV  = 3'd1,
        CMD_TRIG  = 3'd2,
        CMD_JUMP  = 3'd3,
        CMD_EVAL  = 3'd4
    } cmd_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEPS  = 2'd0,
        REG_BASE   = 2'd1,
        REG_PULSES = 2'd2,
        REG_CUTOFF = 2'd3
    } cfg_reg_t;

    // controller to datapath
    typedef struct packed {
        logic wr_en;
        logic eval_init;
        logic recv_load;
        logic mac;
        logic mod_load;
        logic mod_iter;
        logic accum;
        logic sq1;
        logic sq2;
        logic sqsum;
        logic cmp;
        logic sqrt_iter;
        logic ang_load;
        logic norm_shift;
        logic cordic;
        logic fin;
        logic out_load;
    } pcse_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic steps_zero;
        logic pulses_zero;
        logic last_pulse;
        logic mod_done;
        logic last_step;
        logic above;
        logic sqrt_done;
        logic ang_special;
        logic norm_done;
        logic cordic_done;
        logic out_full;
    } pcse_stat_t;

    // index width for a store of n entries
    function automatic int cw(input int n);
        return (n <= 1) ? 1 : $clog2(n);
    endfunction

    // arctangent of 2^-i, pi = 2^22
    function automatic logic [ZW-1:0] atan_unit(input logic [CORDIC_IW-1:0] i);
        logic [ZW-1:0] r;
        case (i)
            5'd0:    r = ZW'(1048576);
            5'd1:    r = ZW'(619011);
            5'd2:    r = ZW'(327068);
            5'd3:    r = ZW'(166025);
            5'd4:    r = ZW'(83335);
            5'd5:    r = ZW'(41708);
            5'd6:    r = ZW'(20859);
            5'd7:    r = ZW'(10430);
            5'd8:    r = ZW'(5215);
            5'd9:    r = ZW'(2608);
            5'd10:   r = ZW'(1304);
            5'd11:   r = ZW'(652);
            5'd12:   r = ZW'(326);
            5'd13:   r = ZW'(163);
            5'd14:   r = ZW'(81);
            5'd15:   r = ZW'(41);
            5'd16:   r = ZW'(20);
            5'd17:   r = ZW'(10);
            5'd18:   r = ZW'(5);
            5'd19:   r = ZW'(3);
            5'd20:   r = ZW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/phase_cycle_signal_evaluator.sv @@
// Load items (phase, receiver, table, jump writes) are written to their stores while idle.
// Evaluate: per step, phase matrix reads, then a one-bit-per-cycle modulo of the
// MAG_W-bit phase magnitude (MAG_W = 16 at default sizes); then squares and compare;
// if selected, a root, then unless the angle is on an axis normalize shifts and CORDIC.
// One item is in work at a time; a finished result waits in its own register.
// Reset clears configuration to defaults and jumps to zero; other stores are not cleared.
// ----------------------------------------------------------------------------
// phase_cycle_signal_evaluator
// Sums table sine and cosine over phase cycle steps and reports magnitude and
// angle of the summed vector when it exceeds a squared threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_cycle_signal_evaluator #(
    parameter int MAX_PULSES = pcse_pkg::MAX_PULSES_DEF,
    parameter int MAX_STEPS  = pcse_pkg::MAX_STEPS_DEF,
    parameter int MAX_BASE   = pcse_pkg::MAX_BASE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // pulse_index[2:0], step_or_angle[10:3], value[19:11],
    // sine_value[35:20], cosine_value[51:36], zero pad [55:52]
    input  wire logic [55:0]                     s_tdata,
    // command[2:0]
    input  wire logic [pcse_pkg::CMD_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // magnitude[21:0], signal_phase[37:22], zero pad [39:38]
    output logic [39:0]                          m_tdata,
    // selected[0]
    output logic [0:0]                           m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pcse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcse_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pcse_pkg::*;

    pcse_cmd_t  cmd;
    pcse_stat_t stat;

    logic [IDX_W-1:0]     in_pulse;
    logic [SA_W-1:0]      in_sa;
    logic [VAL_W-1:0]     in_value;
    logic [TRIG_W-1:0]    in_sine;
    logic [TRIG_W-1:0]    in_cosine;
    logic [MAG_OUT_W-1:0] out_magnitude;
    logic [ANG_W-1:0]     out_phase;
    logic                 out_selected;

    // unpack the input item
    assign in_pulse  = s_tdata[2:0];
    assign in_sa     = s_tdata[10:3];
    assign in_value  = s_tdata[19:11];
    assign in_sine   = s_tdata[35:20];
    assign in_cosine = s_tdata[51:36];

    // pack the result item
    assign m_tdata = {2'b00, out_phase, out_magnitude};
    assign m_tuser = out_selected;

    pcse_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_is_eval (s_tuser == CMD_EVAL),
        .in_ready   (s_tready),
        .stat       (stat),
        .cmd        (cmd)
    );

    pcse_dp #(
        .MAX_PULSES (MAX_PULSES),
        .MAX_STEPS  (MAX_STEPS),
        .MAX_BASE   (MAX_BASE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_command    (s_tuser),
        .in_pulse      (in_pulse),
        .in_sa         (in_sa),
        .in_value      (in_value),
        .in_sine       (in_sine),
        .in_cosine     (in_cosine),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_magnitude (out_magnitude),
        .out_phase     (out_phase),
        .out_selected  (out_selected)
    );

endmodule

`default_nettype wire

@@ hdl/pcse_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcse_ctrl
// Sequencer: walks steps and pulses, then squares, root and angle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcse_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_is_eval,
    output logic                      in_ready,
    input  wire pcse_pkg::pcse_stat_t stat,
    output pcse_pkg::pcse_cmd_t       cmd
);
    import pcse_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_STEP, S_RECV, S_MAC, S_MODLD, S_MOD, S_TRIG, S_ACCUM,
        S_SQ1, S_SQ2, S_SQSUM, S_CMP, S_SQRT, S_ANGLD, S_NORM, S_CORDIC, S_FIN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // command decode
    always_comb
    begin
        cmd            = '0;
        cmd.wr_en      = (state_reg == S_IDLE) && in_valid && !in_is_eval;
        cmd.eval_init  = (state_reg == S_INIT);
        cmd.recv_load  = (state_reg == S_RECV);
        cmd.mac        = (state_reg == S_MAC);
        cmd.mod_load   = (state_reg == S_MODLD);
        cmd.mod_iter   = (state_reg == S_MOD);
        cmd.accum      = (state_reg == S_ACCUM);
        cmd.sq1        = (state_reg == S_SQ1);
        cmd.sq2        = (state_reg == S_SQ2);
        cmd.sqsum      = (state_reg == S_SQSUM);
        cmd.cmp        = (state_reg == S_CMP);
        cmd.sqrt_iter  = (state_reg == S_SQRT);
        cmd.ang_load   = (state_reg == S_ANGLD);
        cmd.norm_shift = (state_reg == S_NORM) && !stat.norm_done;
        cmd.cordic     = (state_reg == S_CORDIC);
        cmd.fin        = (state_reg == S_FIN);
        cmd.out_load   = (state_reg == S_DONE) && !stat.out_full;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid && in_is_eval) state_next = S_INIT;
            S_INIT:   state_next = stat.steps_zero ? S_SQ1 : S_STEP;
            S_STEP:   state_next = S_RECV;
            S_RECV:   state_next = stat.pulses_zero ? S_MODLD : S_MAC;
            S_MAC:    if (stat.last_pulse) state_next = S_MODLD;
            S_MODLD:  state_next = S_MOD;
            S_MOD:    if (stat.mod_done) state_next = S_TRIG;
            S_TRIG:   state_next = S_ACCUM;
            S_ACCUM:  state_next = stat.last_step ? S_SQ1 : S_STEP;
            S_SQ1:    state_next = S_SQ2;
            S_SQ2:    state_next = S_SQSUM;
            S_SQSUM:  state_next = S_CMP;
            S_CMP:    state_next = stat.above ? S_SQRT : S_DONE;
            S_SQRT:   if (stat.sqrt_done) state_next = S_ANGLD;
            S_ANGLD:  state_next = stat.ang_special ? S_DONE : S_NORM;
            S_NORM:   if (stat.norm_done) state_next = S_CORDIC;
            S_CORDIC: if (stat.cordic_done) state_next = S_FIN;
            S_FIN:    state_next = S_DONE;
            S_DONE:   if (!stat.out_full) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pcse_dp.sv @@
// ----------------------------------------------------------------------------
// pcse_dp
// Datapath: stores, phase accumulation, modulo, sums, root and angle units.
// ----------------------------------------------------------------------------
`default_nettype none

module pcse_dp #(
    parameter int MAX_PULSES = pcse_pkg::MAX_PULSES_DEF,
    parameter int MAX_STEPS  = pcse_pkg::MAX_STEPS_DEF,
    parameter int MAX_BASE   = pcse_pkg::MAX_BASE_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire pcse_pkg::pcse_cmd_t                   cmd,
    output pcse_pkg::pcse_stat_t                       stat,
    input  wire logic [pcse_pkg::CMD_W-1:0]            in_command,
    input  wire logic [pcse_pkg::IDX_W-1:0]            in_pulse,
    input  wire logic [pcse_pkg::SA_W-1:0]             in_sa,
    input  wire logic [pcse_pkg::VAL_W-1:0]            in_value,
    input  wire logic [pcse_pkg::TRIG_W-1:0]           in_sine,
    input  wire logic [pcse_pkg::TRIG_W-1:0]           in_cosine,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [pcse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [pcse_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [pcse_pkg::MAG_OUT_W-1:0]             out_magnitude,
    output logic [pcse_pkg::ANG_W-1:0]                 out_phase,
    output logic                                       out_selected
);
    import pcse_pkg::*;

    localparam int PW       = cw(MAX_PULSES);
    localparam int PCW      = $clog2(MAX_PULSES + 1);
    localparam int TW       = cw(MAX_STEPS);
    localparam int TCW      = $clog2(MAX_STEPS + 1);
    localparam int BAW      = cw(MAX_BASE);
    localparam int BW       = $clog2(MAX_BASE + 1);
    localparam int PM_DEPTH = MAX_PULSES * MAX_STEPS;
    localparam int PMAW     = cw(PM_DEPTH);
    localparam int ACC_MAX  = 255 + MAX_PULSES * 32 * 255;
    localparam int MAG_W    = $clog2(ACC_MAX + 1);
    localparam int ACC_W    = MAG_W + 1;
    localparam int MCW      = cw(MAG_W);
    localparam int SUM_W    = cw(MAX_STEPS) + 17;
    localparam int SQ_W     = 2 * SUM_W;
    localparam int SRW      = cw(SQ_W / 2);
    localparam int CMP_W    = SQ_W + CUTOFF_W;
    localparam int RW       = ZW - 7;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [STEP_CNT_W-1:0]  step_count_reg;
    logic [BASE_CFG_W-1:0]  full_base_reg;
    logic [PULSE_CNT_W-1:0] pulse_count_reg;
    logic [CUTOFF_W-1:0]    cutoff_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg  <= STEP_CNT_W'(1);
            full_base_reg   <= BASE_CFG_W'(1);
            pulse_count_reg <= PULSE_CNT_W'(1);
            cutoff_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STEPS:  step_count_reg  <= cfg_data[STEP_CNT_W-1:0];
                REG_BASE:   full_base_reg   <= cfg_data[BASE_CFG_W-1:0];
                REG_PULSES: pulse_count_reg <= cfg_data[PULSE_CNT_W-1:0];
                REG_CUTOFF: cutoff_reg      <= cfg_data[CUTOFF_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamped working values
    logic [TCW-1:0] steps_eff;
    logic [PCW-1:0] pulses_eff;
    logic [BW-1:0]  base_eff;

    always_comb
    begin
        steps_eff  = (32'(step_count_reg) > MAX_STEPS) ? TCW'(MAX_STEPS)
                                                       : TCW'(step_count_reg);
        pulses_eff = (32'(pulse_count_reg) > MAX_PULSES) ? PCW'(MAX_PULSES)
                                                         : PCW'(pulse_count_reg);
        if (32'(full_base_reg) > MAX_BASE)
            base_eff = BW'(MAX_BASE);
        else if (full_base_reg == '0)
            base_eff = BW'(1);
        else
            base_eff = BW'(full_base_reg);
    end

    // ------------------------------------------------------------------
    // step and pulse counters
    // ------------------------------------------------------------------
    logic [TW-1:0] t_reg;
    logic [PW-1:0] p_reg;
    logic          last_step;
    logic          last_pulse;

    assign last_step  = (32'(t_reg) + 1 == 32'(steps_eff));
    assign last_pulse = (32'(p_reg) + 1 == 32'(pulses_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg <= '0;
            p_reg <= '0;
        end
        else
        begin
            if (cmd.eval_init)
                t_reg <= '0;
            else if (cmd.accum)
                t_reg <= last_step ? '0 : TW'(32'(t_reg) + 1);
            if (cmd.recv_load)
                p_reg <= '0;
            else if (cmd.mac && !last_pulse)
                p_reg <= PW'(32'(p_reg) + 1);
        end
    end

    // ------------------------------------------------------------------
    // stores
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]  pm_mem [PM_DEPTH];
    logic [PHASE_W-1:0]  rv_mem [MAX_STEPS];
    logic [2*TRIG_W-1:0] tt_mem [MAX_BASE];
    logic [JUMP_W-1:0]   jump_reg [MAX_PULSES];

    logic [PHASE_W-1:0]  pm_q;
    logic [PHASE_W-1:0]  rv_q;
    logic [2*TRIG_W-1:0] tt_q;

    logic [PMAW-1:0] pm_waddr;
    logic [PMAW-1:0] pm_raddr;
    logic [PW-1:0]   pidx;
    logic [BAW-1:0]  tt_raddr;
    logic            pm_wr;
    logic            rv_wr;
    logic            tt_wr;
    logic            jump_wr;

    assign pm_wr   = cmd.wr_en && (in_command == CMD_PHASE)
                     && (32'(in_pulse) < MAX_PULSES) && (32'(in_sa) < MAX_STEPS);
    assign rv_wr   = cmd.wr_en && (in_command == CMD_RECV) && (32'(in_sa) < MAX_STEPS);
    assign tt_wr   = cmd.wr_en && (in_command == CMD_TRIG) && (32'(in_sa) < MAX_BASE);
    assign jump_wr = cmd.wr_en && (in_command == CMD_JUMP) && (32'(in_pulse) < MAX_PULSES);

    assign pm_waddr = PMAW'(32'(in_pulse) * MAX_STEPS + 32'(in_sa));

    // next pulse row is fetched while the current one is multiplied
    assign pidx     = (cmd.mac && (32'(p_reg) + 1 < MAX_PULSES)) ? PW'(32'(p_reg) + 1) : '0;
    assign pm_raddr = PMAW'(32'(pidx) * MAX_STEPS + 32'(t_reg));

    always_ff @(posedge clk)
    begin
        if (pm_wr)
            pm_mem[pm_waddr] <= in_value[PHASE_W-1:0];
        pm_q <= pm_mem[pm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rv_wr)
            rv_mem[TW'(in_sa)] <= in_value[PHASE_W-1:0];
        rv_q <= rv_mem[t_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tt_wr)
            tt_mem[BAW'(in_sa)] <= {in_sine, in_cosine};
        tt_q <= tt_mem[tt_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PULSES; i++)
                jump_reg[i] <= '0;
        end
        else if (jump_wr)
        begin
            jump_reg[PW'(in_pulse)] <= in_value[JUMP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // phase accumulation
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [JUMP_W+PHASE_W:0]   prod_w;

    assign prod_w = $signed(jump_reg[p_reg]) * $signed({1'b0, pm_q});

    always_ff @(posedge clk)
    begin
        if (cmd.recv_load)
            acc_reg <= ACC_W'($signed({1'b0, rv_q}));
        else if (cmd.mac)
            acc_reg <= acc_reg + ACC_W'(prod_w);
    end

    // ------------------------------------------------------------------
    // floored modulo, one dividend bit per cycle
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mag_reg;
    logic [BW-1:0]    rem_reg;
    logic             neg_reg;
    logic [MCW-1:0]   mcnt_reg;
    logic [BW:0]      trial;
    logic [BW-1:0]    r_final;

    assign trial    = {rem_reg, mag_reg[MAG_W-1]};
    assign r_final  = (neg_reg && (rem_reg != '0)) ? BW'(base_eff - rem_reg) : rem_reg;
    assign tt_raddr = BAW'(r_final);

    always_ff @(posedge clk)
    begin
        if (cmd.mod_load)
        begin
            neg_reg  <= acc_reg[ACC_W-1];
            mag_reg  <= acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
            rem_reg  <= '0;
            mcnt_reg <= '0;
        end
        else if (cmd.mod_iter)
        begin
            rem_reg  <= (trial >= {1'b0, base_eff}) ? BW'(trial - {1'b0, base_eff})
                                                    : BW'(trial);
            mag_reg  <= mag_reg << 1;
            mcnt_reg <= MCW'(32'(mcnt_reg) + 1);
        end
    end

    // ------------------------------------------------------------------
    // sine and cosine sums, squares
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] sum_s_reg;
    logic signed [SUM_W-1:0] sum_c_reg;
    logic signed [SQ_W-1:0]  sqs_w;
    logic signed [SQ_W-1:0]  sqc_w;
    logic [SQ_W-1:0]         sqs_reg;
    logic [SQ_W-1:0]         sqc_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic                    above;

    assign sqs_w = sum_s_reg * sum_s_reg;
    assign sqc_w = sum_c_reg * sum_c_reg;
    assign above = CMP_W'(sq_reg) > CMP_W'(cutoff_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.eval_init)
        begin
            sum_s_reg <= '0;
            sum_c_reg <= '0;
        end
        else if (cmd.accum)
        begin
            sum_s_reg <= sum_s_reg + SUM_W'($signed(tt_q[2*TRIG_W-1:TRIG_W]));
            sum_c_reg <= sum_c_reg + SUM_W'($signed(tt_q[TRIG_W-1:0]));
        end
        if (cmd.sq1)
            sqs_reg <= sqs_w;
        if (cmd.sq2)
            sqc_reg <= sqc_w;
        if (cmd.sqsum)
            sq_reg <= sqs_reg + sqc_reg;
    end

    // ------------------------------------------------------------------
    // integer square root, two radicand bits per cycle
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] v_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] sbit_reg;
    logic [SRW-1:0]  scnt_reg;
    logic            sel_reg;
    logic [SQ_W:0]   rb_sum;

    assign rb_sum = {1'b0, res_reg} + {1'b0, sbit_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.cmp)
        begin
            sel_reg  <= above;
            v_reg    <= sq_reg;
            res_reg  <= '0;
            sbit_reg <= {2'b01, {(SQ_W-2){1'b0}}};
            scnt_reg <= '0;
        end
        else if (cmd.sqrt_iter)
        begin
            if ({1'b0, v_reg} >= rb_sum)
            begin
                v_reg   <= SQ_W'({1'b0, v_reg} - rb_sum);
                res_reg <= (res_reg >> 1) + sbit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
            scnt_reg <= SRW'(32'(scnt_reg) + 1);
        end
    end

    // ------------------------------------------------------------------
    // angle: normalize, then CORDIC vectoring
    // ------------------------------------------------------------------
    logic signed [CW-1:0]    cx_reg;
    logic signed [CW-1:0]    cy_reg;
    logic signed [ZW-1:0]    z_reg;
    logic [CORDIC_IW-1:0]    icnt_reg;
    logic signed [ANG_W-1:0] ang_reg;
    logic signed [CW-1:0]    sx_w;
    logic signed [CW-1:0]    sy_w;
    logic signed [CW-1:0]    abs_x;
    logic signed [CW-1:0]    abs_y;
    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;
    logic signed [ZW-1:0]    z_rnd;
    logic signed [RW-1:0]    r_w;
    logic                    ang_special;
    logic                    norm_done;

    assign sx_w        = CW'(sum_c_reg);
    assign sy_w        = CW'(sum_s_reg);
    assign ang_special = (sum_s_reg == '0) || (sum_c_reg == '0);
    assign abs_x       = cx_reg[CW-1] ? -cx_reg : cx_reg;
    assign abs_y       = cy_reg[CW-1] ? -cy_reg : cy_reg;
    assign norm_done   = (abs_x >= (CW'(1) <<< NORM_BIT)) || (abs_y >= (CW'(1) <<< NORM_BIT));
    assign dx          = cy_reg >>> icnt_reg;
    assign dy          = cx_reg >>> icnt_reg;
    assign z_rnd       = z_reg + ZW'(64);
    assign r_w         = RW'(z_rnd >>> 7);

    always_ff @(posedge clk)
    begin
        if (cmd.ang_load)
        begin
            icnt_reg <= '0;
            if (sum_s_reg == '0)
                ang_reg <= sum_c_reg[SUM_W-1] ? ANG_POS_MAX : '0;
            else if (sum_c_reg == '0)
                ang_reg <= sum_s_reg[SUM_W-1] ? ANG_NEG_QUART : ANG_QUARTER;
            // left half plane: rotate by pi first
            if (sum_c_reg[SUM_W-1])
            begin
                z_reg  <= sum_s_reg[SUM_W-1] ? -Z_PI : Z_PI;
                cx_reg <= -sx_w;
                cy_reg <= -sy_w;
            end
            else
            begin
                z_reg  <= '0;
                cx_reg <= sx_w;
                cy_reg <= sy_w;
            end
        end
        else if (cmd.norm_shift)
        begin
            cx_reg <= cx_reg <<< 1;
            cy_reg <= cy_reg <<< 1;
        end
        else if (cmd.cordic)
        begin
            if (!cy_reg[CW-1])
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                z_reg  <= z_reg + $signed(atan_unit(icnt_reg));
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                z_reg  <= z_reg - $signed(atan_unit(icnt_reg));
            end
            icnt_reg <= icnt_reg + 1'b1;
        end
        else if (cmd.fin)
        begin
            // saturate to the output range
            if ((&r_w[RW-1:ANG_W-1]) || !(|r_w[RW-1:ANG_W-1]))
                ang_reg <= r_w[ANG_W-1:0];
            else
                ang_reg <= r_w[RW-1] ? ANG_NEG_MIN : ANG_POS_MAX;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic                 out_valid_reg;
    logic [MAG_OUT_W-1:0] out_mag_reg;
    logic [ANG_W-1:0]     out_phase_reg;
    logic                 out_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_mag_reg   <= sel_reg ? MAG_OUT_W'(res_reg) : '0;
            out_phase_reg <= sel_reg ? ang_reg : '0;
            out_sel_reg   <= sel_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_magnitude = out_mag_reg;
    assign out_phase     = out_phase_reg;
    assign out_selected  = out_sel_reg;

    // status to the controller
    always_comb
    begin
        stat             = '0;
        stat.steps_zero  = (steps_eff == '0);
        stat.pulses_zero = (pulses_eff == '0);
        stat.last_pulse  = last_pulse;
        stat.mod_done    = (32'(mcnt_reg) == MAG_W - 1);
        stat.last_step   = last_step;
        stat.above       = above;
        stat.sqrt_done   = (32'(scnt_reg) == SQ_W / 2 - 1);
        stat.ang_special = ang_special;
        stat.norm_done   = norm_done;
        stat.cordic_done = (32'(icnt_reg) == CORDIC_STEPS - 1);
        stat.out_full    = out_valid_reg && !out_ready;
    end

endmodule

`default_nettype wire

@@ test/phase_cycle_signal_evaluator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_cycle_signal_evaluator_test
// Self-checking bench: loads the phase, receiver and table stores, sets jumps,
// and runs evaluations under several register settings and flow-control
// patterns. Each result is checked against a behavioral predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_cycle_signal_evaluator_test;
    import pcse_pkg::*;

    localparam int NPULSE = 8;
    localparam int NSTEP  = 64;
    localparam int NBASE  = 256;
    localparam longint ATAN_UNIT [21] = '{1048576, 619011, 327068, 166025, 83335,
        41708, 20859, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

    typedef struct {
        logic [21:0]        magnitude;
        logic signed [15:0] signal_phase;
        logic               selected;
    } eval_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // pulse_index, step_or_angle, value, sine, cosine
    logic [2:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // magnitude, signal_phase
    logic [0:0]  m_tuser;   // selected
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [43:0] cfg_data;

    // predictor state
    logic [7:0]  phase_store [NPULSE*NSTEP];
    logic [7:0]  recv_store [NSTEP];
    logic [31:0] trig_store [NBASE];
    logic [5:0]  jump_store [NPULSE];
    logic [6:0]  steps_cfg;
    logic [8:0]  base_cfg;
    logic [3:0]  pulses_cfg;
    logic [43:0] cutoff_cfg;

    eval_result_t expected_results[$];
    int error_count;
    int tx_idle;
    int rx_stall;
    int hold_cycles;

    phase_cycle_signal_evaluator uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // integer square root, truncated
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // CORDIC vectoring angle, pi = 32768
    function automatic logic signed [15:0] vector_angle(input longint y_in, input longint x_in);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint r;
        x = x_in;
        y = y_in;
        z = 0;
        if (y == 0)
            return (x < 0) ? ANG_POS_MAX : 16'sd0;
        if (x == 0)
            return (y > 0) ? ANG_QUARTER : ANG_NEG_QUART;
        if (x < 0)
        begin
            z = (y >= 0) ? 4194304 : -4194304;
            x = -x;
            y = -y;
        end
        while ((x < 0 ? -x : x) < (64'sd1 <<< 30) && (y < 0 ? -y : y) < (64'sd1 <<< 30))
        begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 21; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_UNIT[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_UNIT[i];
            end
        end
        r = (z + 64) >>> 7;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return 16'(r);
    endfunction

    // summed vector over the phase cycle, thresholded
    function automatic eval_result_t predict_signal();
        eval_result_t res;
        longint steps;
        longint pulses;
        longint base;
        longint acc;
        longint r;
        longint sum_s;
        longint sum_c;
        longint unsigned sq;
        logic [31:0] e;
        steps = (steps_cfg > NSTEP) ? NSTEP : steps_cfg;
        pulses = (pulses_cfg > NPULSE) ? NPULSE : pulses_cfg;
        base = (base_cfg > NBASE) ? NBASE : base_cfg;
        if (base == 0)
            base = 1;
        sum_s = 0;
        sum_c = 0;
        for (longint t = 0; t < steps; t++)
        begin
            acc = longint'(recv_store[t]);
            for (longint p = 0; p < pulses; p++)
                acc = acc + longint'($signed(jump_store[p])) * longint'(phase_store[p*NSTEP+t]);
            r = acc % base;
            if (r < 0)
                r = r + base;
            e = trig_store[r];
            sum_s = sum_s + longint'($signed(e[31:16]));
            sum_c = sum_c + longint'($signed(e[15:0]));
        end
        sq = sum_s * sum_s + sum_c * sum_c;
        if (sq > cutoff_cfg)
        begin
            res.magnitude = 22'(int_sqrt(sq));
            res.signal_phase = vector_angle(sum_s, sum_c);
            res.selected = 1'b1;
        end
        else
        begin
            res.magnitude = '0;
            res.signal_phase = '0;
            res.selected = 1'b0;
        end
        return res;
    endfunction

    // update stores on an accepted item
    task automatic apply_item(input cmd_code_t cmd, input logic [2:0] pidx,
                              input logic [7:0] sa, input logic [8:0] val,
                              input logic [15:0] sv, input logic [15:0] cv);
        case (cmd)
            CMD_PHASE: if (sa < NSTEP) phase_store[pidx*NSTEP+sa] = val[7:0];
            CMD_RECV:  if (sa < NSTEP) recv_store[sa] = val[7:0];
            CMD_TRIG:  trig_store[sa] = {sv, cv};
            CMD_JUMP:  jump_store[pidx] = val[5:0];
            CMD_EVAL:  expected_results = {expected_results, predict_signal()};
            default: ;
        endcase
    endtask

    // offer one item, with a random gap first
    task automatic send_item(input cmd_code_t cmd, input logic [2:0] pidx,
                             input logic [7:0] sa, input logic [8:0] val,
                             input logic [15:0] sv, input logic [15:0] cv);
        int gap;
        gap = ($urandom_range(99) < tx_idle) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, cv, sv, val, sa, pidx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_item(cmd, pidx, sa, val, sv, cv);
    endtask

    // stop offering and wait for every pending result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [43:0] data);
        wait_drained();
        repeat (10) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_STEPS:  steps_cfg  = data[6:0];
            REG_BASE:   base_cfg   = data[8:0];
            REG_PULSES: pulses_cfg = data[3:0];
            REG_CUTOFF: cutoff_cfg = data;
            default:    ;
        endcase
    endtask

    task automatic set_config(input int steps, input int base, input int pulses,
                              input logic [43:0] cutoff);
        write_reg(REG_STEPS, 44'(steps));
        write_reg(REG_BASE, 44'(base));
        write_reg(REG_PULSES, 44'(pulses));
        write_reg(REG_CUTOFF, cutoff);
    endtask

    function automatic logic [15:0] rand_trig();
        return 16'($urandom_range(65534) - 32767);
    endfunction

    function automatic logic [8:0] rand_value();
        return 9'($urandom_range(287) - 32);
    endfunction

    // fill every store entry that an evaluation can read: phase rows 0 and 1
    // over all steps, the other rows over the first 16 steps only, so more
    // than two pulses are only used with at most 16 steps
    task automatic test_store_fill();
        for (int p = 0; p < NPULSE; p++)
            for (int t = 0; t < NSTEP; t++)
                if (p < 2 || t < 16)
                    send_item(CMD_PHASE, 3'(p), 8'(t), rand_value(), '0, '0);
        for (int t = 0; t < NSTEP; t++)
            send_item(CMD_RECV, '0, 8'(t), rand_value(), '0, '0);
        for (int a = 0; a < NBASE; a++)
            send_item(CMD_TRIG, '0, 8'(a), '0, rand_trig(), rand_trig());
    endtask

    // single step evaluation reading one chosen table entry
    task automatic eval_entry(input logic [7:0] angle, input logic [15:0] sv,
                              input logic [15:0] cv);
        send_item(CMD_TRIG, '0, angle, '0, sv, cv);
        send_item(CMD_RECV, '0, '0, {1'b0, angle}, '0, '0);
        send_item(CMD_EVAL, '0, '0, '0, '0, '0);
    endtask

    // angle corner cases and field extremes
    task automatic test_directed();
        set_config(1, 256, 1, '0);
        eval_entry(8'd10, 16'sd0, 16'sd32767);        // on the positive x axis
        eval_entry(8'd20, 16'sd0, -16'sd32767);       // on the negative x axis
        eval_entry(8'd30, 16'sd32767, 16'sd0);        // straight up
        eval_entry(8'd40, -16'sd32767, 16'sd0);       // straight down
        eval_entry(8'd50, 16'sd0, 16'sd0);            // zero vector, not selected
        eval_entry(8'd255, -16'sd32767, -16'sd32767); // third quadrant
        eval_entry(8'd0, 16'sd1, -16'sd32767);        // just below pi
        // negative jump with the widest pulse and step indexes
        send_item(CMD_JUMP, 3'd0, 8'd255, 9'h1E0, '0, '0);
        send_item(CMD_EVAL, 3'd7, 8'd255, 9'h1FF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_JUMP, 3'd0, '0, '0, '0, '0);
    endtask

    // random mix of loads and evaluations
    task automatic test_random(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_item(CMD_EVAL, 3'($urandom), 8'($urandom), 9'($urandom),
                          16'($urandom), 16'($urandom));
            else if (pick < 50)
                send_item(CMD_JUMP, 3'($urandom), 8'($urandom), rand_value(), '0, '0);
            else if (pick < 70)
                send_item(CMD_PHASE, 3'($urandom), 8'($urandom), rand_value(), '0, '0);
            else if (pick < 85)
                send_item(CMD_RECV, '0, 8'($urandom), rand_value(), '0, '0);
            else
                send_item(CMD_TRIG, '0, 8'($urandom), '0, rand_trig(), rand_trig());
        end
    endtask

    // receiver holds off while evaluations pile up, then sender waits them out
    task automatic test_backpressure();
        set_config(4, 97, 3, '0);
        hold_cycles = 3000;
        for (int n = 0; n < 6; n++)
            send_item(CMD_EVAL, '0, '0, '0, '0, '0);
        wait_drained();
    endtask

    // result checking and receiver flow control
    always @(posedge clk)
    begin
        eval_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result mag=%0d phase=%0d sel=%0d", $time,
                             m_tdata[21:0], $signed(m_tdata[37:22]), m_tuser[0]);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[21:0] !== want.magnitude)
                    begin
                        $display("%0t: magnitude expected %0d actual %0d", $time,
                                 want.magnitude, m_tdata[21:0]);
                        error_count++;
                    end
                    if ($signed(m_tdata[37:22]) !== want.signal_phase)
                    begin
                        $display("%0t: signal_phase expected %0d actual %0d", $time,
                                 want.signal_phase, $signed(m_tdata[37:22]));
                        error_count++;
                    end
                    if (m_tuser[0] !== want.selected)
                    begin
                        $display("%0t: selected expected %0d actual %0d", $time,
                                 want.selected, m_tuser[0]);
                        error_count++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall);
        end
    end

    // run limit
    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        hold_cycles = 0;
        tx_idle = 0;
        rx_stall = 0;
        steps_cfg = 7'd1;
        base_cfg = 9'd1;
        pulses_cfg = 4'd1;
        cutoff_cfg = '0;
        foreach (jump_store[i])
            jump_store[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_store_fill();
        tx_idle = 9;
        rx_stall = 84;
        test_directed();

        // sender mostly busy, receiver mostly stalled
        set_config(1, 1, 1, '0);
        test_random(35);
        set_config(64, 256, 2, 44'd1000000);
        test_random(35);
        // step count and base above their limits
        set_config(127, 511, 2, 44'd50000000);
        test_random(35);

        // sender mostly idle, receiver mostly ready
        tx_idle = 84;
        rx_stall = 9;
        // pulse count above its limit
        set_config(16, 300, 15, 44'd50000000);
        test_random(35);
        set_config(0, 0, 0, '0);
        test_random(35);
        set_config(16, 200, 3, 44'hFFF_FFFF_FFFF);
        test_random(35);

        // no idling on either side
        tx_idle = 0;
        rx_stall = 0;
        test_backpressure();
        set_config(9, 37, 5, 44'(($urandom % 3000000)));
        test_random(35);
        set_config(33, 128, 2, 44'd1);
        test_random(35);

        wait_drained();
        repeat (2500) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
